[hw/rtl/sscs_pkg.sv]
`default_nettype none

package sscs_pkg;

    localparam int ENTITY_ID_W = 11;
    localparam int WORD_W      = 32;
    localparam int SLOT_OUT_W  = 8;
    localparam int COUNT_OUT_W = 9;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_PRESENT   = 2'd3;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [ENTITY_ID_W-1:0] entity_id;
        logic [WORD_W-1:0]      component_word;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [WORD_W-1:0]      read_word;
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic [COUNT_OUT_W-1:0] live_count;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/sscs_ram.sv]
`default_nettype none

module sscs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sparse_set_component_store.sv]
// Steps: S_SPARSE reads the sparse entry; a successful lookup then captures the dense
// word in S_DENSE, and a remove that moves the last entry into the freed slot writes
// its sparse entry in S_FIX; S_DONE then waits for the output register. A new request
// is taken only in S_IDLE, once the previous result is loaded into the output register.
// Reset: the live count clears and a clearing pass writes every sparse entry invalid,
// one per cycle; s_ready stays low until it ends.
`default_nettype none

module sparse_set_component_store #(
    parameter int MAX_ENTITIES = 2048,
    parameter int CAPACITY     = 256,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sscs_pkg::req_t s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sscs_pkg::rsp_t     m_payload
);

    import sscs_pkg::*;

    localparam int EW  = $clog2(MAX_ENTITIES);
    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int EXT = (EW > ENTITY_ID_W) ? EW : ENTITY_ID_W;
    localparam int SPW = SW + 1;
    localparam int DNW = EW + DATA_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPARSE,
        S_DENSE,
        S_FIX,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [EW-1:0]         clr_reg;
    logic [CW-1:0]         count_reg;
    logic [1:0]            req_reg;
    logic [EW-1:0]         ent_reg;
    logic                  in_range_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [SW-1:0]         found_reg;
    logic [EW-1:0]         mover_reg;
    logic [1:0]            status_reg;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic [SW-1:0]         slot_reg;
    logic                  m_valid_reg;
    rsp_t                  m_payload_reg;

    logic [EXT-1:0] s_ent_ext;
    logic           s_in_range;

    logic           sp_we;
    logic [EW-1:0]  sp_waddr;
    logic [SPW-1:0] sp_wdata;
    logic [EW-1:0]  sp_raddr;
    logic [SPW-1:0] sp_rdata;

    logic           dn_we;
    logic [SW-1:0]  dn_waddr;
    logic [DNW-1:0] dn_wdata;
    logic [SW-1:0]  dn_raddr;
    logic [DNW-1:0] dn_rdata;

    logic [CW-1:0]  last;
    logic [SW-1:0]  sp_slot;
    logic           present;
    logic           full;
    logic           insert_ok;
    logic           needs_move;

    assign s_ent_ext  = EXT'(s_payload.entity_id);
    assign s_in_range = 32'(s_payload.entity_id) < 32'(MAX_ENTITIES);

    assign last       = count_reg - CW'(1);
    assign sp_slot    = sp_rdata[SW-1:0];
    assign present    = in_range_reg && sp_rdata[SW] && (CW'(sp_slot) < count_reg);
    assign full       = count_reg == CW'(CAPACITY);
    assign insert_ok  = in_range_reg && !present && !full;
    assign needs_move = CW'(sp_slot) < last;

    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Sparse entry: valid mark above the slot number.
    sscs_ram #(
        .WIDTH (SPW),
        .DEPTH (MAX_ENTITIES)
    ) u_sparse (
        .aclk  (aclk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    // Dense entry: owning entity above the component word.
    sscs_ram #(
        .WIDTH (DNW),
        .DEPTH (CAPACITY)
    ) u_dense (
        .aclk  (aclk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    always_comb begin
        sp_we    = 1'b0;
        sp_waddr = ent_reg;
        sp_wdata = '0;
        sp_raddr = s_ent_ext[EW-1:0];
        dn_we    = 1'b0;
        dn_waddr = sp_slot;
        dn_wdata = dn_rdata;
        // The last occupied slot is read along with the sparse entry, ready for a remove.
        dn_raddr = last[SW-1:0];
        case (state_reg)
            S_CLEAR: begin
                sp_we    = 1'b1;
                sp_waddr = clr_reg;
            end
            S_SPARSE: begin
                dn_raddr = sp_slot;
                if (req_reg == REQ_INSERT && insert_ok) begin
                    sp_we    = 1'b1;
                    sp_wdata = {1'b1, count_reg[SW-1:0]};
                    dn_we    = 1'b1;
                    dn_waddr = count_reg[SW-1:0];
                    dn_wdata = {ent_reg, word_reg};
                end else if (req_reg == REQ_REMOVE && present) begin
                    sp_we = 1'b1;
                    dn_we = needs_move;
                end
            end
            S_FIX: begin
                sp_we    = 1'b1;
                sp_waddr = mover_reg;
                sp_wdata = {1'b1, found_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_DONE the output register is always refilled or kept, so it is
            // handled there alone.
            if (m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + EW'(1);
                    if (clr_reg == EW'(MAX_ENTITIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= s_payload.req_type;
                        ent_reg      <= s_ent_ext[EW-1:0];
                        in_range_reg <= s_in_range;
                        word_reg     <= DATA_WIDTH'(s_payload.component_word);
                        state_reg    <= S_SPARSE;
                    end
                end
                S_SPARSE: begin
                    found_reg  <= sp_slot;
                    mover_reg  <= dn_rdata[DNW-1:DATA_WIDTH];
                    status_reg <= ST_NOT_FOUND;
                    rd_reg     <= '0;
                    slot_reg   <= '0;
                    state_reg  <= S_DONE;
                    case (req_reg)
                        REQ_INSERT: begin
                            if (!in_range_reg) begin
                                status_reg <= ST_NOT_FOUND;
                            end else if (present) begin
                                status_reg <= ST_PRESENT;
                            end else if (full) begin
                                status_reg <= ST_FULL;
                            end else begin
                                status_reg <= ST_OK;
                                slot_reg   <= count_reg[SW-1:0];
                                count_reg  <= count_reg + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (present) begin
                                status_reg <= ST_OK;
                                slot_reg   <= sp_slot;
                                count_reg  <= last;
                                if (needs_move) begin
                                    state_reg <= S_FIX;
                                end
                            end
                        end
                        REQ_LOOKUP: begin
                            if (present) begin
                                status_reg <= ST_OK;
                                slot_reg   <= sp_slot;
                                state_reg  <= S_DENSE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_DENSE: begin
                    rd_reg    <= dn_rdata[DATA_WIDTH-1:0];
                    state_reg <= S_DONE;
                end
                S_FIX: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // Hold the finished result until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_payload_reg.status     <= status_reg;
                        m_payload_reg.read_word  <= WORD_W'(rd_reg);
                        m_payload_reg.slot_index <= SLOT_OUT_W'(slot_reg);
                        m_payload_reg.live_count <= COUNT_OUT_W'(count_reg);
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[bench/sparse_set_component_store_test.sv]
`default_nettype none

module sparse_set_component_store_test;
    import sscs_pkg::*;

    localparam int MAXE = 2048;
    localparam int CAP = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam logic [1:0] REQ_UNDEFINED = 2'd3;

    typedef enum {MIX_MODE, FILL_MODE, DRAIN_MODE} mix_t;

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t ans;
    } probe_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_payload;

    // Shadow copy of the store contents.
    logic [WORD_W-1:0]      sh_words [CAP];
    logic [ENTITY_ID_W-1:0] sh_owner [CAP];
    logic [8:0]             sh_slot [MAXE];
    bit                     sh_live [MAXE];
    int                     sh_count;

    rsp_t   answers_due [$];
    probe_t probes [$];
    int     mismatches = 0;
    int     cycles = 0;
    int     items_sent = 0;
    int     burst_left = 0;
    bit     tx_quiet = 1'b0;
    bit     hold_off_req = 1'b0;

    sparse_set_component_store #(
        .MAX_ENTITIES(MAXE),
        .CAPACITY(CAP),
        .DATA_WIDTH(WORD_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Applies one request to the shadow store and returns the answer it gives.
    function automatic rsp_t set_access(req_t rq);
        rsp_t r;
        logic [ENTITY_ID_W-1:0] ent;
        logic [SLOT_OUT_W-1:0]  found;
        logic [SLOT_OUT_W-1:0]  last;
        logic [SLOT_OUT_W-1:0]  tail;
        logic [ENTITY_ID_W-1:0] mover;
        bit present;
        r = '0;
        r.status = ST_NOT_FOUND;
        ent = rq.entity_id;
        present = sh_live[ent] && (int'(sh_slot[ent]) < sh_count);
        found = sh_slot[ent][SLOT_OUT_W-1:0];
        case (rq.req_type)
            REQ_INSERT: begin
                if (present) begin
                    r.status = ST_PRESENT;
                end else if (sh_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    tail = SLOT_OUT_W'(sh_count);
                    sh_words[tail] = rq.component_word;
                    sh_owner[tail] = rq.entity_id;
                    sh_slot[ent] = {1'b0, tail};
                    sh_live[ent] = 1'b1;
                    r.slot_index = tail;
                    sh_count++;
                    r.status = ST_OK;
                end
            end
            REQ_REMOVE: begin
                if (present) begin
                    last = SLOT_OUT_W'(sh_count - 1);
                    // The last entry fills the hole unless the hole is the last slot.
                    if (found < last) begin
                        mover = sh_owner[last];
                        sh_words[found] = sh_words[last];
                        sh_owner[found] = sh_owner[last];
                        sh_slot[mover] = {1'b0, found};
                    end
                    sh_live[ent] = 1'b0;
                    sh_count = sh_count - 1;
                    r.slot_index = found;
                    r.status = ST_OK;
                end
            end
            REQ_LOOKUP: begin
                if (present) begin
                    r.read_word = sh_words[found];
                    r.slot_index = found;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.live_count = COUNT_OUT_W'(sh_count);
        return r;
    endfunction

    function automatic logic [ENTITY_ID_W-1:0] live_entity();
        if (sh_count == 0)
            return ENTITY_ID_W'($urandom_range(0, MAXE - 1));
        return sh_owner[SLOT_OUT_W'($urandom_range(0, sh_count - 1))];
    endfunction

    function automatic req_t draw_request(mix_t mode);
        req_t rq;
        int r;
        r = $urandom_range(0, 99);
        rq.component_word = $urandom;
        rq.entity_id = ENTITY_ID_W'($urandom_range(0, MAXE - 1));
        case (mode)
            MIX_MODE: begin
                if (r < 35) begin
                    rq.req_type = REQ_INSERT;
                    if (r < 10) rq.entity_id = live_entity();
                end else if (r < 65) begin
                    rq.req_type = REQ_REMOVE;
                    if (r < 59) rq.entity_id = live_entity();
                end else if (r < 95) begin
                    rq.req_type = REQ_LOOKUP;
                    if (r < 89) rq.entity_id = live_entity();
                end else begin
                    rq.req_type = REQ_UNDEFINED;
                end
            end
            FILL_MODE: begin
                if (r < 85) begin
                    rq.req_type = REQ_INSERT;
                end else if (r < 90) begin
                    rq.req_type = REQ_INSERT;
                    rq.entity_id = live_entity();
                end else begin
                    rq.req_type = REQ_LOOKUP;
                    rq.entity_id = live_entity();
                end
            end
            default: begin
                if (r < 70) begin
                    rq.req_type = REQ_REMOVE;
                    rq.entity_id = live_entity();
                end else if (r < 85) begin
                    rq.req_type = REQ_LOOKUP;
                    rq.entity_id = live_entity();
                end else if (r < 95) begin
                    rq.req_type = REQ_INSERT;
                end else begin
                    rq.req_type = REQ_REMOVE;
                end
            end
        endcase
        return rq;
    endfunction

    task automatic add_probe(input logic [1:0] op, input int id, input logic [31:0] w,
                             input int typed, input logic [1:0] st, input logic [31:0] rd,
                             input int slot, input int cnt);
        probe_t p;
        p.rq.req_type = op;
        p.rq.entity_id = ENTITY_ID_W'(id);
        p.rq.component_word = w;
        p.typed = (typed != 0);
        p.ans.status = st;
        p.ans.read_word = rd;
        p.ans.slot_index = SLOT_OUT_W'(slot);
        p.ans.live_count = COUNT_OUT_W'(cnt);
        probes = {probes, p};
    endtask

    // Offers one beat, waits for it to be taken, then idles for a drawn gap.
    task automatic offer(input req_t rq, input bit typed, input rsp_t ans);
        rsp_t got;
        int gap;
        s_valid <= 1'b1;
        s_payload <= rq;
        do @(posedge aclk); while (s_ready !== 1'b1);
        got = set_access(rq);
        answers_due = {answers_due, (typed ? ans : got)};
        items_sent++;
        if (items_sent % 25 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = tx_quiet ? 0 : $urandom_range(0, 12);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_answers();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        rsp_t none;
        none = '0;
        sh_count = 0;
        foreach (sh_live[k]) begin
            sh_live[k] = 1'b0;
            sh_slot[k] = '0;
        end

        add_probe(REQ_LOOKUP,    0,    0,            1, ST_NOT_FOUND, 0,            0, 0);
        add_probe(REQ_REMOVE,    2047, 0,            1, ST_NOT_FOUND, 0,            0, 0);
        add_probe(REQ_UNDEFINED, 5,    32'h1234_5678, 1, ST_NOT_FOUND, 0,           0, 0);
        add_probe(REQ_INSERT,    0,    32'h0000_0000, 1, ST_OK,       0,            0, 1);
        add_probe(REQ_INSERT,    2047, 32'hFFFF_FFFF, 1, ST_OK,       0,            1, 2);
        add_probe(REQ_INSERT,    0,    32'h0000_1234, 1, ST_PRESENT,  0,            0, 2);
        add_probe(REQ_LOOKUP,    2047, 0,            1, ST_OK,        32'hFFFF_FFFF, 1, 2);
        add_probe(REQ_LOOKUP,    0,    32'hFFFF_FFFF, 1, ST_OK,       0,            0, 2);
        add_probe(REQ_INSERT,    1024, 32'h5555_5555, 0, ST_OK, 0, 0, 0);
        add_probe(REQ_INSERT,    1,    32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0);
        add_probe(REQ_INSERT,    2,    32'h8000_0001, 0, ST_OK, 0, 0, 0);
        // Removing slot 0 pulls entity 2 down from the end.
        add_probe(REQ_REMOVE,    0,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_LOOKUP,    2,    0,            0, ST_OK, 0, 0, 0);
        // Entity 1 now sits in the last slot, so nothing moves.
        add_probe(REQ_REMOVE,    1,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_LOOKUP,    1,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_REMOVE,    1,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_UNDEFINED, 2047, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0);
        add_probe(REQ_LOOKUP,    1024, 0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_REMOVE,    2047, 0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_LOOKUP,    1024, 0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_INSERT,    1,    32'h0000_FFFF, 0, ST_OK, 0, 0, 0);
        add_probe(REQ_REMOVE,    2,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_REMOVE,    1024, 0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_REMOVE,    1,    0,            0, ST_OK, 0, 0, 0);
        add_probe(REQ_LOOKUP,    1,    0,            1, ST_NOT_FOUND, 0,            0, 0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probes[k])
            offer(probes[k].rq, probes[k].typed, probes[k].ans);

        for (n = 0; n < 30; n++)
            offer(draw_request(MIX_MODE), 1'b0, none);

        drain_answers();

        // Results are held back while beats keep coming, so the input side backs up.
        hold_off_req = 1'b1;
        burst_left = 40;
        while (sh_count < CAP)
            offer(draw_request(FILL_MODE), 1'b0, none);
        for (n = 0; n < 10; n++)
            offer(draw_request(FILL_MODE), 1'b0, none);
        for (n = 0; n < 40; n++)
            offer(draw_request(DRAIN_MODE), 1'b0, none);
        for (n = 0; n < 15; n++)
            offer(draw_request(MIX_MODE), 1'b0, none);

        drain_answers();
        repeat (12) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int w;
        int seen;
        bit rx_quiet;
        rsp_t got;
        rsp_t want;
        seen = 0;
        rx_quiet = 1'b0;
        forever begin
            if (seen % 25 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            w = rx_quiet ? 0 : $urandom_range(0, 12);
            if (hold_off_req) begin
                w = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1 || m_ready !== 1'b1);
            got = m_payload;
            seen++;
            if (answers_due.size() == 0) begin
                $display("%0t: result beat expected none outstanding, got %h", $time, got);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.read_word !== want.read_word) begin
                    $display("%0t: read_word expected %h, got %h",
                             $time, want.read_word, got.read_word);
                    mismatches++;
                end
                if (got.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index expected %0d, got %0d",
                             $time, want.slot_index, got.slot_index);
                    mismatches++;
                end
                if (got.live_count !== want.live_count) begin
                    $display("%0t: live_count expected %0d, got %0d",
                             $time, want.live_count, got.live_count);
                    mismatches++;
                end
            end
        end
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/sscs_pkg.sv
hw/rtl/sscs_ram.sv
hw/rtl/sparse_set_component_store.sv
bench/sparse_set_component_store_test.sv
